### sv/sfrd_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// No dependencies.
package sfrd_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_CRC_ENABLE    = 2'd0,
		CFG_BOUNDARY_BYTE = 2'd1,
		CFG_ESCAPE_BYTE   = 2'd2,
		CFG_ESCAPE_MASK   = 2'd3
	} cfg_index_t;

	typedef logic [7:0]  byte_t;
	typedef logic [14:0] len_t;
	typedef logic [15:0] crc_t;
	typedef logic [15:0] count_t;
	typedef logic [1:0]  hdr_size_t;

	// CRC-16 (reflected polynomial) constants.
	localparam crc_t CRC_POLY = 16'hA001;
	localparam crc_t CRC_INIT = 16'hFFFF;

	// Length byte: top bit selects the two-byte form.
	localparam byte_t LEN_LONG_BIT = 8'h80;
	localparam byte_t LEN_LOW_MASK = 8'h7F;

	// Header sizes: command plus one or two length bytes.
	localparam hdr_size_t HDR_SHORT = 2'd2;
	localparam hdr_size_t HDR_LONG  = 2'd3;

	// Register reset values.
	localparam logic  RST_CRC_ENABLE    = 1'b1;
	localparam byte_t RST_BOUNDARY_BYTE = 8'h7E;
	localparam byte_t RST_ESCAPE_BYTE   = 8'h7D;
	localparam byte_t RST_ESCAPE_MASK   = 8'h20;

	// One byte through the CRC, bit by bit, LSB first.
	function automatic crc_t crc16_byte(input crc_t crc_in, input byte_t data);
		crc_t c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### sv/serial_frame_receive_deframer_top.sv
// Byte-stuffed serial frame deframer with CRC-16 check: top level.
// Depends on sfrd_pkg.
//
// Usage:
// Line bytes enter on the input channel (in_valid, in_stall, rx_byte), one
// request per byte. Escape bytes and bytes outside a frame produce no result.
// Each payload byte, each frame end and each aborted frame produces one result
// request on the output channel (out_valid, out_stall and the result fields).
// A byte is captured in the input register, decoded against the framing
// state in the next cycle and written into the result register, from which
// its result is offered; a held result can keep the byte in the input register.
// Throughput is one byte per cycle without stalls; the framing state and the
// CRC update sit in one short path between the input and result registers.
// When the receiver stalls, the held result stays in place and only bytes
// that would produce a new result wait in the input register; bytes that
// produce no result still pass. Stall reaches the input side in the same cycle.
// Reset clears all framing state, sets the CRC to all ones and loads the
// configuration registers with their defaults (CRC on, boundary 0x7E, escape
// 0x7D, mask 0x20). The user must write configuration only while idle (unchecked).
module serial_frame_receive_deframer_top (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port
	input  logic                cfg_write_en,
	input  sfrd_pkg::cfg_index_t cfg_index,
	input  logic [7:0]          cfg_data,
	// Input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	// Output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                payload_valid,
	output logic [7:0]          payload_byte,
	output logic [14:0]         payload_index,
	output logic                frame_done,
	output logic [7:0]          frame_command,
	output logic [14:0]         frame_length,
	output logic                crc_ok,
	output logic                frame_aborted
);
	import sfrd_pkg::*;

	// Configuration registers
	logic      crc_enable_q;
	byte_t     boundary_byte_q;
	byte_t     escape_byte_q;
	byte_t     escape_mask_q;

	// Framing state
	logic      escape_pending_q;
	count_t    byte_count_q;
	hdr_size_t header_size_q;
	len_t      expected_length_q;
	crc_t      running_crc_q;
	byte_t     command_hold_q;

	// Input register
	logic      valid_s1;
	byte_t     byte_s1;

	// Result register
	logic      out_valid_q;
	logic      res_payload_valid_q;
	byte_t     res_payload_byte_q;
	len_t      res_payload_index_q;
	logic      res_frame_done_q;
	byte_t     res_frame_command_q;
	len_t      res_frame_length_q;
	logic      res_crc_ok_q;
	logic      res_frame_aborted_q;

	// Decode results
	logic      is_escape;
	byte_t     data_byte;
	logic      is_boundary;
	count_t    payload_offset;
	count_t    count_inc;
	logic [16:0] frame_total;
	crc_t      crc_base;
	crc_t      crc_upd;

	logic      escape_pending_nxt;
	count_t    byte_count_nxt;
	hdr_size_t header_size_nxt;
	len_t      expected_length_nxt;
	crc_t      running_crc_nxt;
	byte_t     command_hold_nxt;

	logic      res_pv;
	byte_t     res_pb;
	len_t      res_pi;
	logic      res_done;
	logic      res_ok;
	logic      res_abort;
	logic      has_result;
	logic      advance_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_enable_q    <= RST_CRC_ENABLE;
			boundary_byte_q <= RST_BOUNDARY_BYTE;
			escape_byte_q   <= RST_ESCAPE_BYTE;
			escape_mask_q   <= RST_ESCAPE_MASK;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_CRC_ENABLE:    crc_enable_q    <= cfg_data[0];
				CFG_BOUNDARY_BYTE: boundary_byte_q <= cfg_data;
				CFG_ESCAPE_BYTE:   escape_byte_q   <= cfg_data;
				CFG_ESCAPE_MASK:   escape_mask_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Byte decode: unescape, boundary test, header and payload tracking, CRC.
	always_comb begin
		is_escape   = (byte_s1 == escape_byte_q);
		data_byte   = escape_pending_q ? (byte_s1 ^ escape_mask_q) : byte_s1;
		is_boundary = (data_byte == boundary_byte_q) && !escape_pending_q;

		payload_offset = byte_count_q - {14'd0, header_size_q};
		count_inc      = byte_count_q + 16'd1;
		crc_base       = ((byte_count_q == '0) && crc_enable_q) ? CRC_INIT : running_crc_q;
		crc_upd        = crc16_byte(crc_base, data_byte);

		escape_pending_nxt  = escape_pending_q;
		byte_count_nxt      = byte_count_q;
		header_size_nxt     = header_size_q;
		expected_length_nxt = expected_length_q;
		running_crc_nxt     = running_crc_q;
		command_hold_nxt    = command_hold_q;
		frame_total         = '0;

		res_pv    = 1'b0;
		res_pb    = '0;
		res_pi    = '0;
		res_done  = 1'b0;
		res_ok    = 1'b0;
		res_abort = 1'b0;

		if (is_escape) begin
			escape_pending_nxt = 1'b1;
		end else begin
			escape_pending_nxt = 1'b0;
			if (is_boundary) begin
				res_abort      = (byte_count_q != '0);
				byte_count_nxt = '0;
			end else begin
				if (byte_count_q == 16'd0) begin
					command_hold_nxt = data_byte;
				end else if (byte_count_q == 16'd1) begin
					if ((data_byte & LEN_LONG_BIT) != '0) begin
						header_size_nxt     = HDR_LONG;
						expected_length_nxt = {data_byte[6:0], 8'h00};
					end else begin
						header_size_nxt     = HDR_SHORT;
						expected_length_nxt = {7'd0, data_byte};
					end
				end else if ((byte_count_q == 16'd2) && (header_size_q == HDR_LONG)) begin
					expected_length_nxt = expected_length_q + {7'd0, data_byte};
				end else if (payload_offset < {1'b0, expected_length_q}) begin
					res_pv = 1'b1;
					res_pb = data_byte;
					res_pi = payload_offset[14:0];
				end
				if (crc_enable_q) begin
					running_crc_nxt = crc_upd;
				end
				// Frame end: header, payload and optional CRC bytes all taken.
				frame_total = {2'd0, expected_length_nxt} + {15'd0, header_size_nxt}
					+ {15'd0, crc_enable_q, 1'b0};
				if ({1'b0, count_inc} == frame_total) begin
					byte_count_nxt = '0;
					res_done       = 1'b1;
					res_ok         = !crc_enable_q || (running_crc_nxt == '0);
				end else begin
					byte_count_nxt = count_inc;
				end
			end
		end
		has_result = res_pv || res_done || res_abort;
	end

	// Handshake: a byte moves on unless it has a result and the slot is held.
	assign advance_s1 = valid_s1 && (!has_result || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Framing state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_pending_q  <= 1'b0;
			byte_count_q      <= '0;
			header_size_q     <= HDR_SHORT;
			expected_length_q <= '0;
			running_crc_q     <= CRC_INIT;
			command_hold_q    <= '0;
		end else if (advance_s1) begin
			escape_pending_q  <= escape_pending_nxt;
			byte_count_q      <= byte_count_nxt;
			header_size_q     <= header_size_nxt;
			expected_length_q <= expected_length_nxt;
			running_crc_q     <= running_crc_nxt;
			command_hold_q    <= command_hold_nxt;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance_s1 && has_result) begin
			res_payload_valid_q <= res_pv;
			res_payload_byte_q  <= res_pb;
			res_payload_index_q <= res_pi;
			res_frame_done_q    <= res_done;
			res_frame_command_q <= command_hold_nxt;
			res_frame_length_q  <= expected_length_nxt;
			res_crc_ok_q        <= res_ok;
			res_frame_aborted_q <= res_abort;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_valid = res_payload_valid_q;
	assign payload_byte  = res_payload_byte_q;
	assign payload_index = res_payload_index_q;
	assign frame_done    = res_frame_done_q;
	assign frame_command = res_frame_command_q;
	assign frame_length  = res_frame_length_q;
	assign crc_ok        = res_crc_ok_q;
	assign frame_aborted = res_frame_aborted_q;

`ifndef SYNTHESIS
	// Every result request carries at least one event.
	a_result_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (payload_valid || frame_done || frame_aborted))
		else $error("result without payload, frame end or abort");

	// A frame cannot end on the same byte that aborts it.
	a_done_not_abort: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && frame_aborted))
		else $error("frame end and abort in one result");

	// The CRC flag is only reported with a frame end.
	a_crc_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_done) |-> !crc_ok)
		else $error("crc_ok without frame end");

	// Payload fields are zero when no payload byte is carried.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !payload_valid) |-> (payload_byte == '0 && payload_index == '0))
		else $error("payload fields set without a payload byte");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the byte-stuffed frame deframer: directed frames first,
// then random framed traffic under random idling on both channels.
// Depends on sfrd_pkg and serial_frame_receive_deframer_top.
module testbench;
	import sfrd_pkg::*;

	// A result request passes the input and result registers; allow some slack.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_BYTES  = 1300;
	// About 1500 line bytes; even with the longest gaps and stalls this is far above need.
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic  pay_valid;
		byte_t pay_byte;
		len_t  pay_index;
		logic  done;
		byte_t command;
		len_t  length;
		logic  crc_good;
		logic  aborted;
	} frame_event_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write_en = 1'b0;
	cfg_index_t cfg_index = CFG_CRC_ENABLE;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [14:0] payload_index;
	logic       frame_done;
	logic [7:0] frame_command;
	logic [14:0] frame_length;
	logic       crc_ok;
	logic       frame_aborted;

	// Register copies and framing state of the predictor.
	logic      cfg_crc_on;
	byte_t     cfg_boundary;
	byte_t     cfg_escape;
	byte_t     cfg_mask;
	logic      rx_escaped;
	count_t    rx_count;
	hdr_size_t rx_hdr_size;
	len_t      rx_length;
	crc_t      rx_crc;
	byte_t     rx_command;

	frame_event_t awaited_events[$];
	byte_t        frame_body[$];
	crc_t         tx_crc;
	int           cycle_count = 0;
	int           mismatch_count = 0;
	int unsigned  line_bytes_sent = 0;
	int unsigned  burst_left = 0;
	logic         valid_held = 1'b0;
	int unsigned  stall_mode = 0;
	int unsigned  stall_left = 0;

	serial_frame_receive_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_done(frame_done),
		.frame_command(frame_command),
		.frame_length(frame_length),
		.crc_ok(crc_ok),
		.frame_aborted(frame_aborted)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// CRC-16, reflected, one data bit per step with the feedback taken up front.
	function automatic crc_t crc_next(input crc_t crc_in, input byte_t data);
		crc_t x;
		logic fb;
		x = crc_in;
		for (int i = 0; i < 8; i++) begin
			fb = x[0] ^ data[i];
			x = {1'b0, x[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return x;
	endfunction

	function automatic void clear_deframer_state();
		cfg_crc_on   = RST_CRC_ENABLE;
		cfg_boundary = RST_BOUNDARY_BYTE;
		cfg_escape   = RST_ESCAPE_BYTE;
		cfg_mask     = RST_ESCAPE_MASK;
		rx_escaped   = 1'b0;
		rx_count     = '0;
		rx_hdr_size  = HDR_SHORT;
		rx_length    = '0;
		rx_crc       = CRC_INIT;
		rx_command   = '0;
		awaited_events.delete();
	endfunction

	function automatic void apply_reg_write(input cfg_index_t idx, input byte_t value);
		case (idx)
			CFG_CRC_ENABLE:    cfg_crc_on = value[0];
			CFG_BOUNDARY_BYTE: cfg_boundary = value;
			CFG_ESCAPE_BYTE:   cfg_escape = value;
			CFG_ESCAPE_MASK:   cfg_mask = value;
			default: ;
		endcase
	endfunction

	// Advance the framing state by one line byte and queue the event it causes, if any.
	function automatic void deframe_line_byte(input byte_t raw);
		byte_t        b;
		frame_event_t ev;
		int unsigned  offset;
		ev = '0;
		b = raw;
		// The escape byte is swallowed, even right after another escape.
		if (b == cfg_escape) begin
			rx_escaped = 1'b1;
			return;
		end
		if (rx_escaped) begin
			b = b ^ cfg_mask;
		end
		if (b == cfg_boundary && !rx_escaped) begin
			ev.aborted = (rx_count != 0);
			rx_count = '0;
		end else begin
			if (rx_count == 0) begin
				rx_command = b;
				if (cfg_crc_on) begin
					rx_crc = CRC_INIT;
				end
			end else if (rx_count == 1) begin
				if ((b & LEN_LONG_BIT) != 0) begin
					rx_hdr_size = HDR_LONG;
					rx_length = {b[6:0], 8'h00};
				end else begin
					rx_hdr_size = HDR_SHORT;
					rx_length = len_t'(b);
				end
			end else if (rx_count == 2 && rx_hdr_size == HDR_LONG) begin
				rx_length = rx_length + len_t'(b);
			end else begin
				offset = 32'(rx_count) - 32'(rx_hdr_size);
				if (offset < 32'(rx_length)) begin
					ev.pay_valid = 1'b1;
					ev.pay_byte = b;
					ev.pay_index = len_t'(offset);
				end
			end
			if (cfg_crc_on) begin
				rx_crc = crc_next(rx_crc, b);
			end
			rx_count = rx_count + 16'd1;
			if (32'(rx_count) == 32'(rx_length) + 32'(rx_hdr_size)
					+ (cfg_crc_on ? 32'd2 : 32'd0)) begin
				rx_count = '0;
				ev.done = 1'b1;
				ev.crc_good = !cfg_crc_on || rx_crc == 16'h0000;
			end
		end
		rx_escaped = 1'b0;
		ev.command = rx_command;
		ev.length = rx_length;
		if (ev.pay_valid || ev.done || ev.aborted) begin
			awaited_events = {awaited_events, ev};
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Compare one accepted result request with the oldest awaited event.
	task automatic check_frame_event;
		frame_event_t want;
		if (awaited_events.size() == 0) begin
			report_mismatch("result request arrived with no event awaited");
			return;
		end
		want = awaited_events.pop_front();
		check_field("payload_valid", 16'(payload_valid), 16'(want.pay_valid));
		check_field("payload_byte", 16'(payload_byte), 16'(want.pay_byte));
		check_field("payload_index", 16'(payload_index), 16'(want.pay_index));
		check_field("frame_done", 16'(frame_done), 16'(want.done));
		check_field("frame_command", 16'(frame_command), 16'(want.command));
		check_field("frame_length", 16'(frame_length), 16'(want.length));
		check_field("crc_ok", 16'(crc_ok), 16'(want.crc_good));
		check_field("frame_aborted", 16'(frame_aborted), 16'(want.aborted));
	endtask

	// Track register writes and accepted bytes, then check accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_deframer_state();
		end else begin
			if (cfg_write_en) begin
				apply_reg_write(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				deframe_line_byte(rx_byte);
			end
			if (out_valid && !out_stall) begin
				check_frame_event();
			end
		end
	end

	// Receiver stall pattern: modes from never stalling to stalling most cycles.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Send one line byte as an input request; bursts end in a random gap.
	task automatic send_byte(input byte_t b);
		int unsigned gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		valid_held = 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		line_bytes_sent++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			valid_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Escape the byte when it collides with the boundary or escape value.
	task automatic send_stuffed(input byte_t b);
		if (b == cfg_escape || b == cfg_boundary) begin
			send_byte(cfg_escape);
			send_byte(b ^ cfg_mask);
		end else begin
			send_byte(b);
		end
	endtask

	task automatic send_logical(input byte_t b);
		tx_crc = crc_next(tx_crc, b);
		send_stuffed(b);
	endtask

	// Boundary (unless it equals the escape), command, length, frame_body and, when enabled, the CRC low byte first.
	task automatic send_frame(input byte_t cmd, input bit long_form, input bit bad_crc);
		int unsigned n;
		crc_t        c;
		n = frame_body.size();
		if (cfg_boundary != cfg_escape) begin
			send_byte(cfg_boundary);
		end
		tx_crc = CRC_INIT;
		send_logical(cmd);
		if (long_form || n > 127) begin
			send_logical({1'b1, n[14:8]});
			send_logical(n[7:0]);
		end else begin
			send_logical(n[7:0]);
		end
		foreach (frame_body[i]) begin
			send_logical(frame_body[i]);
		end
		if (cfg_crc_on) begin
			c = tx_crc;
			if (bad_crc) begin
				c = c ^ (16'h0001 << $urandom_range(0, 15));
			end
			send_stuffed(c[7:0]);
			send_stuffed(c[15:8]);
		end
	endtask

	// Random byte, biased toward the framing values and the extremes.
	function automatic byte_t pick_byte();
		case ($urandom_range(0, 11))
			0: return cfg_boundary;
			1: return cfg_escape;
			2: return 8'h00;
			3: return 8'hFF;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void fill_body(input int unsigned n);
		frame_body.delete();
		repeat (n) frame_body = {frame_body, pick_byte()};
	endfunction

	// Lower valid, wait for every awaited event and let any quiet bytes drain.
	task automatic wait_idle;
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		@(posedge clk);
		while (awaited_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input byte_t value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_config(input logic crc_on, input byte_t boundary,
			input byte_t escape, input byte_t mask);
		wait_idle();
		write_reg(CFG_CRC_ENABLE, {7'd0, crc_on});
		write_reg(CFG_BOUNDARY_BYTE, boundary);
		write_reg(CFG_ESCAPE_BYTE, escape);
		write_reg(CFG_ESCAPE_MASK, mask);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Reset defaults: stray boundaries, a CRC frame with escaped data, an abort.
	task automatic test_basic_frames;
		send_byte(RST_BOUNDARY_BYTE);
		send_byte(RST_BOUNDARY_BYTE);
		frame_body = '{8'h7E, 8'h00, 8'h7D};
		send_frame(8'hFF, 1'b0, 1'b0);
		send_byte(RST_BOUNDARY_BYTE);
		send_logical(8'h42);
		send_byte(RST_BOUNDARY_BYTE);
	endtask

	// Without CRC: empty payload, single payload byte that ends the frame,
	// and a doubled escape in front of a data byte.
	task automatic test_plain_frames;
		set_config(1'b0, RST_BOUNDARY_BYTE, RST_ESCAPE_BYTE, RST_ESCAPE_MASK);
		frame_body.delete();
		send_frame(8'h00, 1'b0, 1'b0);
		frame_body = '{8'hFF};
		send_frame(8'h80, 1'b0, 1'b0);
		send_byte(RST_BOUNDARY_BYTE);
		send_byte(8'h01);
		send_byte(8'h01);
		send_byte(RST_ESCAPE_BYTE);
		send_byte(RST_ESCAPE_BYTE);
		send_byte(8'h5D);
	endtask

	// Two-byte length: the largest length cut off by a boundary, then a short one.
	task automatic test_long_length;
		send_byte(RST_BOUNDARY_BYTE);
		send_logical(8'h5A);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_logical(8'h00);
		send_logical(8'hFF);
		send_byte(RST_BOUNDARY_BYTE);
		frame_body = '{8'h11, 8'h22};
		send_frame(8'h33, 1'b1, 1'b0);
	endtask

	// CRC switched off mid-frame: the count runs past the frame end until a boundary.
	task automatic test_crc_toggle_mid_frame;
		set_config(1'b1, RST_BOUNDARY_BYTE, RST_ESCAPE_BYTE, RST_ESCAPE_MASK);
		send_byte(RST_BOUNDARY_BYTE);
		tx_crc = CRC_INIT;
		send_logical(8'hC3);
		send_logical(8'h01);
		send_logical(8'h7D);
		set_config(1'b0, RST_BOUNDARY_BYTE, RST_ESCAPE_BYTE, RST_ESCAPE_MASK);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(RST_BOUNDARY_BYTE);
		set_config(1'b1, RST_BOUNDARY_BYTE, RST_ESCAPE_BYTE, RST_ESCAPE_MASK);
		frame_body.delete();
		send_frame(8'h01, 1'b0, 1'b0);
	endtask

	// Escape and boundary share a value, so the escape wins and framing runs on count.
	task automatic test_escape_equals_boundary;
		set_config(1'b1, 8'h00, 8'h00, 8'hFF);
		frame_body = '{8'h00, 8'h7E};
		send_frame(8'h00, 1'b0, 1'b0);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Phases of random settings, each carrying mostly well-formed frames plus noise.
	task automatic test_random_traffic;
		int unsigned target;
		int unsigned kind;
		int unsigned n;
		target = line_bytes_sent + RANDOM_BYTES;
		while (line_bytes_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: set_config(1'($urandom_range(0, 1)), RST_BOUNDARY_BYTE,
					RST_ESCAPE_BYTE, RST_ESCAPE_MASK);
				4, 5, 6: set_config(1'($urandom_range(0, 1)),
					byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
					byte_t'($urandom_range(1, 255)));
				7: set_config(1'b1, 8'h00, 8'hFF, 8'hFF);
				8: set_config(1'b0, 8'hFF, 8'h00, 8'h80);
				default: set_config(1'($urandom_range(0, 1)),
					byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
					8'h00);
			endcase
			repeat ($urandom_range(3, 10)) begin
				kind = $urandom_range(0, 99);
				if (kind < 72) begin
					n = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 140)
						: $urandom_range(0, 10);
					fill_body(n);
					send_frame(pick_byte(), $urandom_range(0, 4) == 0,
						$urandom_range(0, 9) == 0);
				end else if (kind < 82) begin
					// Partial frame cut off by a boundary.
					send_byte(cfg_boundary);
					repeat ($urandom_range(1, 6)) send_logical(pick_byte());
					send_byte(cfg_boundary);
				end else if (kind < 92) begin
					repeat ($urandom_range(1, 8)) send_byte(pick_byte());
				end else begin
					repeat ($urandom_range(1, 3)) send_byte(cfg_escape);
					send_byte(pick_byte());
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_frames();
		test_plain_frames();
		test_long_length();
		test_crc_toggle_mid_frame();
		test_escape_equals_boundary();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_events.size() != 0) begin
			report_mismatch($sformatf("%0d events never arrived", awaited_events.size()));
		end
		if (mismatch_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
